### rtl/ptf_pkg.sv
// shared types, widths and helper function for the periodic timer forward block
`default_nettype none
package ptf_pkg;

    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 63;
    localparam int RES_W    = 30;
    localparam int SAT_W    = 63;
    localparam int CNT_W    = 64;
    localparam int STAT_W   = 2;
    localparam int DIV_STEPS = PERIOD_W;

    localparam logic [RES_W-1:0] RES_RESET = RES_W'(1);
    localparam logic [SAT_W-1:0] SAT_RESET = SAT_W'(64'd9223372036000000000);

    // register indexes of the configuration port
    localparam logic CFG_RESOLUTION = 1'b0;
    localparam logic CFG_SATURATE   = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_FORWARDED = 2'd0;
    localparam logic [STAT_W-1:0] ST_ENQUEUED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EARLY     = 2'd2;

    // item as it travels through the divider stages
    typedef struct packed {
        logic [TIME_W-1:0]   expiry;
        logic [TIME_W-1:0]   now;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] delta;
        logic [PERIOD_W-1:0] num;
        logic [PERIOD_W-1:0] rem;
        logic [PERIOD_W-1:0] quo;
        logic                enq;
        logic                early;
        logic                short_late;
    } ptf_div_t;

    // saturating expiry addition
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b,
                                                  input logic [SAT_W-1:0] satv);
        logic [TIME_W-1:0] t;
        t = a + b;
        if (t[TIME_W-1] || ($signed(t) < $signed(a)) || ($signed(t) < $signed(b)))
            t = {1'b0, satv};
        return t;
    endfunction

endpackage
`default_nettype wire

### rtl/ptf_prep.sv
// input stage: lateness, effective period and classification
`default_nettype none
module ptf_prep
    import ptf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire logic [TIME_W-1:0]   expiry,
    input  wire logic [TIME_W-1:0]   now,
    input  wire logic [PERIOD_W-1:0] period,
    input  wire logic                enq,
    input  wire logic [RES_W-1:0]    resolution,
    output logic                     out_valid,
    output ptf_div_t                 out_item
);

    logic [TIME_W-1:0]   delta;
    logic [RES_W-1:0]    res_eff;
    logic [PERIOD_W-1:0] per_eff;
    ptf_div_t            item_next;
    logic                valid_reg;
    ptf_div_t            item_reg;

    // lateness and period floor
    always_comb
    begin
        delta   = now - expiry;
        res_eff = (resolution == '0) ? RES_W'(1) : resolution;
        per_eff = (period < PERIOD_W'(res_eff)) ? PERIOD_W'(res_eff) : period;
        item_next.expiry = expiry;
        item_next.now    = now;
        item_next.period = per_eff;
        item_next.delta  = delta[PERIOD_W-1:0];
        item_next.num    = delta[PERIOD_W-1:0];
        item_next.rem    = '0;
        item_next.quo    = '0;
        item_next.enq    = enq;
        item_next.early  = delta[TIME_W-1];
        item_next.short_late = delta[PERIOD_W-1:0] < per_eff;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

### rtl/ptf_div_step.sv
// one restoring division step: one quotient bit per stage
`default_nettype none
module ptf_div_step
    import ptf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     adv,
    input  wire logic     in_valid,
    input  wire ptf_div_t in_item,
    output logic          out_valid,
    output ptf_div_t      out_item
);

    logic [PERIOD_W:0] trial;
    logic [PERIOD_W:0] diff;
    logic              fits;
    ptf_div_t          item_next;
    logic              valid_reg;
    ptf_div_t          item_reg;

    // shift in next dividend bit, compare and subtract
    always_comb
    begin
        trial = {in_item.rem, in_item.num[PERIOD_W-1]};
        diff  = trial - {1'b0, in_item.period};
        fits  = trial >= {1'b0, in_item.period};
        item_next     = in_item;
        item_next.rem = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        item_next.num = {in_item.num[PERIOD_W-2:0], 1'b0};
        item_next.quo = {in_item.quo[PERIOD_W-2:0], fits};
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

### rtl/ptf_fwd.sv
// forwarding stages: advance by whole periods, then one more if still due
`default_nettype none
module ptf_fwd
    import ptf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire ptf_div_t          in_item,
    input  wire logic [SAT_W-1:0]  saturate,
    output logic                   out_valid,
    output logic [TIME_W-1:0]      new_expiry,
    output logic [CNT_W-1:0]       overrun,
    output logic [STAT_W-1:0]      status
);

    // first stage: increment and count
    logic                v0_reg;
    logic [TIME_W-1:0]   exp0_reg;
    logic [TIME_W-1:0]   now0_reg;
    logic [PERIOD_W-1:0] per0_reg;
    logic [TIME_W-1:0]   inc0_reg;
    logic [CNT_W-1:0]    cnt0_reg;
    logic [STAT_W-1:0]   st0_reg;
    logic                short0_reg;
    logic [TIME_W-1:0]   inc0_next;
    logic [CNT_W-1:0]    cnt0_next;
    logic [STAT_W-1:0]   st0_next;

    // second stage: first saturating add
    logic                v1_reg;
    logic [TIME_W-1:0]   orig1_reg;
    logic [TIME_W-1:0]   e1_reg;
    logic [TIME_W-1:0]   now1_reg;
    logic [PERIOD_W-1:0] per1_reg;
    logic [CNT_W-1:0]    cnt1_reg;
    logic [STAT_W-1:0]   st1_reg;
    logic                short1_reg;

    logic [TIME_W-1:0]   e2;

    always_comb
    begin
        inc0_next = in_item.short_late ? {1'b0, in_item.period}
                                       : {1'b0, in_item.delta - in_item.rem};
        cnt0_next = in_item.short_late ? CNT_W'(1) : {1'b0, in_item.quo};
        if (in_item.enq)
            st0_next = ST_ENQUEUED;
        else if (in_item.early)
            st0_next = ST_EARLY;
        else
            st0_next = ST_FORWARDED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            exp0_reg   <= in_item.expiry;
            now0_reg   <= in_item.now;
            per0_reg   <= in_item.period;
            inc0_reg   <= inc0_next;
            cnt0_reg   <= cnt0_next;
            st0_reg    <= st0_next;
            short0_reg <= in_item.short_late;
            orig1_reg  <= exp0_reg;
            e1_reg     <= sat_add(exp0_reg, inc0_reg, saturate);
            now1_reg   <= now0_reg;
            per1_reg   <= per0_reg;
            cnt1_reg   <= cnt0_reg;
            st1_reg    <= st0_reg;
            short1_reg <= short0_reg;
        end
    end

    // final choice: done, or one more period
    always_comb
    begin
        e2         = sat_add(e1_reg, {1'b0, per1_reg}, saturate);
        out_valid  = v1_reg;
        status     = st1_reg;
        if (st1_reg != ST_FORWARDED)
        begin
            new_expiry = orig1_reg;
            overrun    = '0;
        end
        else if (short1_reg || ($signed(now1_reg) < $signed(e1_reg)))
        begin
            new_expiry = e1_reg;
            overrun    = cnt1_reg;
        end
        else
        begin
            new_expiry = e2;
            overrun    = cnt1_reg + CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

### rtl/periodic_timer_forward.sv
// Periodic timer forward block.
// Input stream s_*: tdata holds expiry_time, now_time, period_ns (low bits up),
// tuser holds is_enqueued. Output stream m_*: tdata holds new_expiry and
// overrun_count, tuser holds the status code.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 resolution_ns,
// 1 saturate_to) and cfg_data; cfg_ready is always high. Write only while idle.
// From input acceptance to m_tvalid an item passes one input stage,
// 63 divider stages (one quotient bit each), two forwarding stages and the
// output register. One item is taken per cycle while m_tready does not stall
// the output; the 63-step divider pipeline sets the depth.
// When m_tready is low while a result is held, the whole pipeline freezes
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads resolution 1 and the default
// saturation value.
`default_nettype none
module periodic_timer_forward
    import ptf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // expiry_time, now_time, period_ns, pad
    input  wire logic         s_tuser,   // is_enqueued
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // new_expiry, overrun_count
    output logic [1:0]        m_tuser,   // status
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [62:0]  cfg_data
);

    logic              adv;
    logic [RES_W-1:0]  res_reg;
    logic [SAT_W-1:0]  sat_reg;
    logic              dv [DIV_STEPS+1];
    ptf_div_t          di [DIV_STEPS+1];
    logic              fv;
    logic [TIME_W-1:0] f_exp;
    logic [CNT_W-1:0]  f_cnt;
    logic [STAT_W-1:0] f_st;
    logic              m_valid_reg;
    logic [127:0]      m_data_reg;
    logic [1:0]        m_user_reg;

    // pipeline moves when the output register is free or being taken
    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RES_RESET;
            sat_reg <= SAT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RESOLUTION: res_reg <= cfg_data[RES_W-1:0];
                CFG_SATURATE:   sat_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    ptf_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .expiry     (s_tdata[63:0]),
        .now        (s_tdata[127:64]),
        .period     (s_tdata[190:128]),
        .enq        (s_tuser),
        .resolution (res_reg),
        .out_valid  (dv[0]),
        .out_item   (di[0])
    );

    // divider chain
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        ptf_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv[k]),
            .in_item   (di[k]),
            .out_valid (dv[k+1]),
            .out_item  (di[k+1])
        );
    end

    ptf_fwd u_fwd (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (dv[DIV_STEPS]),
        .in_item    (di[DIV_STEPS]),
        .saturate   (sat_reg),
        .out_valid  (fv),
        .new_expiry (f_exp),
        .overrun    (f_cnt),
        .status     (f_st)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= fv;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {f_cnt, f_exp};
            m_user_reg <= f_st;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

### rtl/ptf_checker.sv
// port-level checks for the periodic timer forward block
`default_nettype none
module ptf_checker
    import ptf_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // only defined status codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_FORWARDED || m_tuser == ST_ENQUEUED
                      || m_tuser == ST_EARLY))
        else $error("bad status code");

    // untouched timers report no overrun
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_FORWARDED |-> m_tdata[127:64] == '0)
        else $error("overrun on untouched timer");

    // a forwarded timer crossed at least one period
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FORWARDED |-> m_tdata[127:64] != '0)
        else $error("forwarded with zero overrun");

endmodule

bind periodic_timer_forward ptf_checker u_ptf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
